>>> hw/rtl/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Shared constants and types for the lowest common ancestor block.
// ----------------------------------------------------------------------------
package lca_pkg;

   localparam int NODES  = 1024;
   localparam int NODE_W = $clog2(NODES);
   localparam int LINK_W = 11;
   localparam int CNT_W  = $clog2(NODES + 1);
   localparam int CNT_REG_W  = 11;
   localparam int ROOT_REG_W = 10;
   localparam int STAT_W = 2;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_WALK  = 2'd2;

   localparam logic REG_NODE_COUNT = 1'b0;
   localparam logic REG_ROOT_NODE  = 1'b1;

   localparam logic signed [LINK_W-1:0] NO_PARENT = '1;

   typedef struct packed {
      logic [CNT_W-1:0]  cnt;
      logic [NODE_W-1:0] root;
   } lca_cfg_type;

   typedef struct packed {
      logic signed [LINK_W-1:0] ancestor;
      logic [STAT_W-1:0]        status;
   } lca_result_type;

endpackage

>>> hw/rtl/lca_ram.sv
// ----------------------------------------------------------------------------
// lca_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lca_engine.sv
// ----------------------------------------------------------------------------
// lca_engine
// Parent link table and the walk sequencer: depth measure, lift, meet.
// ----------------------------------------------------------------------------
module lca_engine
   import lca_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  lca_cfg_type              cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic [NODE_W-1:0]        req_node_a,
   input  logic [NODE_W-1:0]        req_node_b,
   input  logic signed [LINK_W-1:0] req_parent_link,
   output logic                     res_valid,
   output lca_result_type           res,
   input  logic                     res_take
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DEP_RD = 3'd1;
   localparam logic [2:0] S_DEP_EV = 3'd2;
   localparam logic [2:0] S_LIFT   = 3'd3;
   localparam logic [2:0] S_UPA    = 3'd4;
   localparam logic [2:0] S_UPB    = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic              phase_ff, phase_in;
   logic [NODE_W-1:0] x_ff, x_in;
   logic [NODE_W-1:0] xa_ff, xa_in;
   logic [NODE_W-1:0] xb_ff, xb_in;
   logic [CNT_W-1:0]  da_ff, da_in;
   logic [CNT_W-1:0]  db_ff, db_in;
   lca_result_type    res_ff, res_in;

   logic              wr_en;
   logic [LINK_W-1:0] wr_data;
   logic [NODE_W-1:0] rd_addr;
   logic [LINK_W-1:0] rd_data;

   logic [LINK_W-1:0] link_u;
   logic              a_bad, b_bad, link_bad;
   logic [CNT_W-1:0]  d_cur;

   assign link_u   = req_parent_link;
   assign a_bad    = CNT_W'(req_node_a) >= cfg.cnt;
   assign b_bad    = CNT_W'(req_node_b) >= cfg.cnt;
   assign link_bad = !link_u[LINK_W-1] && (CNT_W'(link_u[NODE_W-1:0]) >= cfg.cnt);
   assign d_cur    = phase_ff ? db_ff : da_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   // a negative link is stored as all ones
   assign wr_en   = req_ready && req_valid && (req_op == OP_WRITE) && !a_bad && !link_bad;
   assign wr_data = link_u[LINK_W-1] ? NO_PARENT : link_u;

   lca_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NODES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_node_a),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      x_in     = x_ff;
      xa_in    = xa_ff;
      xb_in    = xb_ff;
      da_in    = da_ff;
      db_in    = db_ff;
      res_in   = res_ff;
      rd_addr  = x_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in.ancestor = NO_PARENT;
               res_in.status   = ST_OK;
               state_in        = S_DONE;
               if (req_op == OP_WRITE) begin
                  if (a_bad || link_bad) begin
                     res_in.status = ST_RANGE;
                  end
               end else if (a_bad || b_bad) begin
                  res_in.status = ST_RANGE;
               end else begin
                  xa_in    = req_node_a;
                  xb_in    = req_node_b;
                  x_in     = req_node_a;
                  da_in    = '0;
                  db_in    = '0;
                  phase_in = 1'b0;
                  state_in = S_DEP_RD;
               end
            end
         end
         S_DEP_RD: begin
            if (x_ff == cfg.root) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  x_in     = xb_ff;
               end else begin
                  state_in = S_LIFT;
               end
            end else begin
               state_in = S_DEP_EV;
            end
         end
         S_DEP_EV: begin
            if (rd_data[LINK_W-1]) begin
               state_in = S_DEP_RD;
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  x_in     = xb_ff;
               end else begin
                  state_in = S_LIFT;
               end
            end else if (CNT_W'(rd_data[NODE_W-1:0]) >= cfg.cnt) begin
               res_in.status = ST_RANGE;
               state_in      = S_DONE;
            end else if (d_cur >= CNT_W'(NODES)) begin
               res_in.status = ST_WALK;
               state_in      = S_DONE;
            end else begin
               x_in     = rd_data[NODE_W-1:0];
               state_in = S_DEP_RD;
               if (phase_ff) begin
                  db_in = db_ff + 1'b1;
               end else begin
                  da_in = da_ff + 1'b1;
               end
            end
         end
         S_LIFT: begin
            if (da_ff > db_ff) begin
               rd_addr  = xa_ff;
               state_in = S_UPA;
            end else if (db_ff > da_ff) begin
               rd_addr  = xb_ff;
               state_in = S_UPB;
            end else if ((xa_ff != xb_ff) && (da_ff != '0)) begin
               rd_addr  = xa_ff;
               state_in = S_UPA;
            end else begin
               state_in = S_DONE;
               if (xa_ff == xb_ff) begin
                  res_in.ancestor = $signed({1'b0, xa_ff});
               end else begin
                  res_in.status = ST_WALK;
               end
            end
         end
         S_UPA: begin
            // equal depths here means a joint step: fetch b's parent next
            xa_in = rd_data[NODE_W-1:0];
            if (da_ff == db_ff) begin
               rd_addr  = xb_ff;
               state_in = S_UPB;
            end else begin
               da_in    = da_ff - 1'b1;
               state_in = S_LIFT;
            end
         end
         S_UPB: begin
            xb_in    = rd_data[NODE_W-1:0];
            state_in = S_LIFT;
            if (da_ff == db_ff) begin
               da_in = da_ff - 1'b1;
               db_in = db_ff - 1'b1;
            end else begin
               db_in = db_ff - 1'b1;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      phase_ff <= phase_in;
      x_ff     <= x_in;
      xa_ff    <= xa_in;
      xb_ff    <= xb_in;
      da_ff    <= da_in;
      db_ff    <= db_in;
      res_ff   <= res_in;
   end

endmodule

>>> hw/rtl/lowest_common_ancestor.sv
// ----------------------------------------------------------------------------
// lowest_common_ancestor
// Parent link table with lowest common ancestor queries; configuration over an APB port.
// ----------------------------------------------------------------------------
// One item at a time. A query walks the parent link memory, which has one
// read port with a registered read: it measures the depths of both nodes,
// lifts the deeper node, and then steps both nodes up together until they
// meet. A walk that runs into a loop ends with the walk status. The result
// sits in an output register, so the next item is taken while the previous
// result waits. The link table is not cleared at reset; query only nodes
// whose parent entries have been written.
module lowest_common_ancestor
   import lca_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic [NODE_W-1:0]        req_node_a,
   input  logic [NODE_W-1:0]        req_node_b,
   input  logic signed [LINK_W-1:0] req_parent_link,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [LINK_W-1:0] rsp_ancestor,
   output logic [STAT_W-1:0]        rsp_status,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [ADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   logic [CNT_REG_W-1:0]  node_count_ff, node_count_in;
   logic [ROOT_REG_W-1:0] root_node_ff, root_node_in;
   logic                  csr_wr;
   logic                  reg_sel;

   logic                  rsp_valid_ff, rsp_valid_in;
   lca_result_type        rsp_ff, rsp_in;

   lca_cfg_type           cfg;
   logic                  res_valid;
   lca_result_type        res;
   logic                  res_take;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign reg_sel = paddr[2];

   always_comb begin
      node_count_in = node_count_ff;
      root_node_in  = root_node_ff;
      if (csr_wr) begin
         case (reg_sel)
            REG_NODE_COUNT: node_count_in = pwdata[CNT_REG_W-1:0];
            REG_ROOT_NODE:  root_node_in  = pwdata[ROOT_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_NODE_COUNT: prdata = DATA_W'(node_count_ff);
         REG_ROOT_NODE:  prdata = DATA_W'(root_node_ff);
         default:        prdata = '0;
      endcase
   end

   // indices below min(node_count, NODES) are valid
   assign cfg.cnt  = (node_count_ff > CNT_REG_W'(NODES)) ? CNT_W'(NODES)
                                                         : CNT_W'(node_count_ff);
   assign cfg.root = root_node_ff[NODE_W-1:0];

   lca_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_parent_link (req_parent_link),
      .res_valid       (res_valid),
      .res             (res),
      .res_take        (res_take)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_REG_W'(1);
         root_node_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         root_node_ff  <= root_node_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_ff.ancestor;
   assign rsp_status   = rsp_ff.status;

endmodule

>>> hw/rtl/lca_checker.sv
// ----------------------------------------------------------------------------
// lca_checker
// Port-level checks for the lowest common ancestor block, bound to the top.
// ----------------------------------------------------------------------------
module lca_checker
   import lca_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [LINK_W-1:0] rsp_ancestor,
   input logic [STAT_W-1:0]        rsp_status
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ancestor) && $stable(rsp_status))
      else $error("result changed while stalled");

   // errors never carry an ancestor
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_ancestor == NO_PARENT)
      else $error("error result with ancestor");

   // one item in flight: the block is busy right after taking an item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   // only the three defined status codes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_RANGE) ||
                    (rsp_status == ST_WALK))
      else $error("undefined status code");

endmodule

bind lowest_common_ancestor lca_checker u_lca_checker (.*);
